// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// checked at every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_CLK_ALWAYS(label, clk, prop)

`endif

`endif

// ----- design/rag_pkg.sv -----
// ----------------------------------------------------------------------------
// rag_pkg
// widths, constants and stage types of the radial alpha gradient
// ----------------------------------------------------------------------------
`default_nettype none

package rag_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIM_W      = 13;
    localparam int COLOR_W    = 24;
    localparam int ALPHA_W    = 8;
    localparam int ARGB_W     = ALPHA_W + COLOR_W;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COLOR_W;

    localparam int DIFF_W = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int RHS_W  = SUM_W + SCALE_W;
    localparam int R_W    = DIM_W - 1;
    localparam int Q_W    = 2 * R_W + 2;
    localparam int P_W    = Q_W + ALPHA_W;
    localparam int S_W    = Q_W + 2 * ALPHA_W;
    localparam int CMP_W  = ((RHS_W > S_W) ? RHS_W : S_W) + 2;

    localparam int PREP_STAGES = 3;
    localparam int LATENCY     = PREP_STAGES + ALPHA_W + 1;

    localparam logic [SCALE_W-1:0] ALPHA_SQ  = 16'd65025;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLOR  = 2'd2;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd256;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd256;
    localparam logic [COLOR_W-1:0] COLOR_RST  = 24'd0;

    // one item inside the alpha search
    typedef struct packed {
        logic [RHS_W-1:0]   rhs;
        logic [Q_W-1:0]     q;
        logic [S_W-1:0]     s;
        logic [P_W-1:0]     p;
        logic [ALPHA_W-1:0] a;
        logic               zero_r;
    } search_t;

endpackage

`default_nettype wire

// ----- design/rag_prep.sv -----
// ----------------------------------------------------------------------------
// rag_prep
// three-stage front end: center offsets, squares and scaled squared distance
// ----------------------------------------------------------------------------
`default_nettype none

module rag_prep
    import rag_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [COORD_BITS-1:0] pixel_x,
    input  wire logic [COORD_BITS-1:0] pixel_y,
    input  wire logic [DIM_W-1:0]      image_width,
    input  wire logic [DIM_W-1:0]      image_height,
    output logic                       out_valid,
    output search_t                    out_data
);

    logic [PREP_STAGES-1:0] valid_reg;

    logic [DIFF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [R_W-1:0]    r_reg, r_next;
    logic [SQ_W-1:0]   sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [Q_W-1:0]    q1_reg, q1_next, q2_reg;
    logic              zero1_reg, zero1_next, zero2_reg;
    logic [RHS_W-1:0]  rhs_reg, rhs_next;

    logic [DIFF_W-1:0] twice_x, twice_y, w_ext, h_ext;
    logic [DIM_W-1:0]  dim_min;
    logic [SUM_W-1:0]  sum;

    // stage 1: offsets from the doubled center
    always_comb
    begin
        twice_x = DIFF_W'({pixel_x, 1'b0});
        twice_y = DIFF_W'({pixel_y, 1'b0});
        w_ext   = DIFF_W'(image_width);
        h_ext   = DIFF_W'(image_height);
        dx_next = (twice_x >= w_ext) ? twice_x - w_ext : w_ext - twice_x;
        dy_next = (twice_y >= h_ext) ? twice_y - h_ext : h_ext - twice_y;
        dim_min = (image_height > image_width) ? image_width : image_height;
        r_next  = dim_min[DIM_W-1:1];
    end

    // stage 2: squares
    always_comb
    begin
        sqx_next   = SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_next   = SQ_W'(dy_reg) * SQ_W'(dy_reg);
        q1_next    = (Q_W'(r_reg) * Q_W'(r_reg)) << 2;
        zero1_next = (r_reg == '0);
    end

    // stage 3: scaled squared distance
    always_comb
    begin
        sum      = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        rhs_next = RHS_W'(sum) * RHS_W'(ALPHA_SQ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PREP_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        r_reg     <= r_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        q1_reg    <= q1_next;
        zero1_reg <= zero1_next;
        q2_reg    <= q1_reg;
        zero2_reg <= zero1_reg;
        rhs_reg   <= rhs_next;
    end

    always_comb
    begin
        out_valid       = valid_reg[PREP_STAGES-1];
        out_data.rhs    = rhs_reg;
        out_data.q      = q2_reg;
        out_data.s      = '0;
        out_data.p      = '0;
        out_data.a      = '0;
        out_data.zero_r = zero2_reg;
    end

endmodule

`default_nettype wire

// ----- design/rag_search.sv -----
// ----------------------------------------------------------------------------
// rag_search
// pipelined bit-by-bit alpha search, one alpha bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rag_search
    import rag_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire search_t in_data,
    output logic         out_valid,
    output search_t      out_data
);

    localparam int LAST = ALPHA_W - 1;

    logic [ALPHA_W-1:0] valid_reg;
    logic [ALPHA_W-1:0] stage_valid;
    search_t            stage_in  [ALPHA_W];
    search_t            stage_reg [ALPHA_W];
    search_t            stage_next[ALPHA_W];

    for (genvar i = 0; i < ALPHA_W; i++)
    begin : g_step
        localparam int B = ALPHA_W - 1 - i;

        logic [CMP_W-1:0] cand;
        logic             take;

        if (i == 0)
        begin : g_first
            assign stage_in[i]    = in_data;
            assign stage_valid[i] = in_valid;
        end
        else
        begin : g_rest
            assign stage_in[i]    = stage_reg[i-1];
            assign stage_valid[i] = valid_reg[i-1];
        end

        // q*(a + 2^b)^2 built from q*a^2 and q*a
        always_comb
        begin
            cand = CMP_W'(stage_in[i].s)
                 + (CMP_W'(stage_in[i].p) << (B + 1))
                 + (CMP_W'(stage_in[i].q) << (2 * B));
            take = (cand <= CMP_W'(stage_in[i].rhs));
            stage_next[i] = stage_in[i];
            if (take)
            begin
                stage_next[i].s = cand[S_W-1:0];
                stage_next[i].p = stage_in[i].p + (P_W'(stage_in[i].q) << B);
                stage_next[i].a = stage_in[i].a | (ALPHA_W'(1) << B);
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[i] <= stage_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= stage_valid;
        end
    end

    assign out_valid = valid_reg[LAST];
    assign out_data  = stage_reg[LAST];

    `ASSERT_CLK(a_search_fits, clk, rst_n,
        valid_reg[LAST] |-> (CMP_W'(stage_reg[LAST].s) <= CMP_W'(stage_reg[LAST].rhs)))
    `ASSERT_CLK(a_search_p, clk, rst_n,
        valid_reg[LAST] |-> (stage_reg[LAST].p ==
            P_W'(stage_reg[LAST].q) * P_W'(stage_reg[LAST].a)))

endmodule

`default_nettype wire

// ----- design/radial_alpha_gradient.sv -----
// ----------------------------------------------------------------------------
// radial_alpha_gradient
// radial alpha mask generator: one ARGB pixel per pixel coordinate
// ----------------------------------------------------------------------------
// One coordinate is taken on every clock edge with start high; busy is always
// low. Each transfer yields exactly one pixel on done, after it has passed
// through 3 front-end stages (offsets, squares, scaled distance), 8 search
// stages that each settle one alpha bit, and the output register. done is high
// for one cycle only and the receiver cannot stall it. The configuration port
// is always ready; write it only while no pixels are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module radial_alpha_gradient
    import rag_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] pixel_x,
    input  wire logic [COORD_BITS-1:0] pixel_y,
    output logic                       done,
    output logic [ALPHA_W-1:0]         alpha_value,
    output logic [ARGB_W-1:0]          argb_pixel,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               done_reg;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;

    logic    accept;
    logic    prep_valid, search_valid;
    search_t prep_data, search_data;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            color_reg  <= COLOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_IDX_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_IDX_COLOR:  color_reg  <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    rag_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (prep_valid),
        .out_data     (prep_data)
    );

    rag_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .out_valid (search_valid),
        .out_data  (search_data)
    );

    // zero radius saturates
    assign alpha_next = search_data.zero_r ? ALPHA_MAX : search_data.a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= search_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= alpha_next;
    end

    assign done        = done_reg;
    assign alpha_value = alpha_reg;
    assign argb_pixel  = {alpha_reg, color_reg};

    `ASSERT_CLK(a_latency, clk, rst_n, accept |-> ##LATENCY done)
    `ASSERT_CLK(a_no_spurious, clk, rst_n, done |-> $past(accept, LATENCY))

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench of the radial alpha gradient: an internal predictor computes the
// exact integer alpha for every accepted coordinate under the current image
// size and color, and each pixel on done is compared field by field with the
// oldest pending prediction. Directed tests cover reset values, every
// register, zero radius, size and coordinate extremes and off-image pixels,
// followed by random image settings with bursty coordinate streams.
// ----------------------------------------------------------------------------
module tb;
    import rag_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_ITEMS = 850;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct {
        logic [ALPHA_W-1:0] alpha;
        logic [ARGB_W-1:0]  argb;
    } pixel_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    logic [COORD_BITS-1:0] pixel_x   = '0;
    logic [COORD_BITS-1:0] pixel_y   = '0;
    logic                  done;
    logic [ALPHA_W-1:0]    alpha_value;
    logic [ARGB_W-1:0]     argb_pixel;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [DIM_W-1:0]   img_width  = WIDTH_RST;
    logic [DIM_W-1:0]   img_height = HEIGHT_RST;
    logic [COLOR_W-1:0] img_color  = COLOR_RST;

    pixel_t pending_pixels[$];
    pixel_t got_pixel;
    int     pixels_sent    = 0;
    int     pixels_checked = 0;
    int     mismatches     = 0;
    int     reg_writes     = 0;
    int     image_settings = 0;
    int     burst_left     = 0;
    int     cycle_count    = 0;

    radial_alpha_gradient u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .done        (done),
        .alpha_value (alpha_value),
        .argb_pixel  (argb_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // largest a with (2*r*a)^2 <= 65025*((2x-w)^2 + (2y-h)^2)
    function automatic logic [ALPHA_W-1:0] radial_alpha(input logic [COORD_BITS-1:0] x,
                                                        input logic [COORD_BITS-1:0] y);
        longint unsigned w, h, r, dx, dy, dist_sq, t;
        logic [ALPHA_W-1:0] a, cand;
        w = 64'(img_width);
        h = 64'(img_height);
        r = ((h > w) ? w : h) >> 1;
        if (r == 0)
            return ALPHA_MAX;
        dx = (2 * longint'(x) >= w) ? 2 * longint'(x) - w : w - 2 * longint'(x);
        dy = (2 * longint'(y) >= h) ? 2 * longint'(y) - h : h - 2 * longint'(y);
        dist_sq = (dx * dx + dy * dy) * ALPHA_SQ;
        a = '0;
        for (int b = ALPHA_W - 1; b >= 0; b--)
        begin
            cand = a;
            cand[b] = 1'b1;
            t = 2 * r * cand;
            if (t * t <= dist_sq)
                a = cand;
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("mismatch on %s at cycle %0d: got 0x%0h, expected 0x%0h",
                 what, cycle_count, got, exp);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected pixel", argb_pixel, 0);
            else
            begin
                got_pixel = pending_pixels.pop_front();
                if (alpha_value !== got_pixel.alpha)
                    report_mismatch("alpha_value", alpha_value, got_pixel.alpha);
                if (argb_pixel !== got_pixel.argb)
                    report_mismatch("argb_pixel", argb_pixel, got_pixel.argb);
                pixels_checked++;
            end
        end
    end

    task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        pixel_t exp;
        int gap;
        cfg_valid <= 1'b0;
        start     <= 1'b1;
        pixel_x   <= x;
        pixel_y   <= y;
        do @(posedge clk); while (busy);
        exp.alpha = radial_alpha(x, y);
        exp.argb  = {exp.alpha, img_color};
        pending_pixels.push_back(exp);
        pixels_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_pixels();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_IDX_WIDTH:  img_width  = data[DIM_W-1:0];
            CFG_IDX_HEIGHT: img_height = data[DIM_W-1:0];
            CFG_IDX_COLOR:  img_color  = data[COLOR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_image(input int w, input int h, input logic [COLOR_W-1:0] color);
        drain_pixels();
        write_register(CFG_IDX_WIDTH, CFG_DATA_W'(w));
        write_register(CFG_IDX_HEIGHT, CFG_DATA_W'(h));
        write_register(CFG_IDX_COLOR, color);
        image_settings++;
    endtask

    task automatic test_reset_state();
        send_pixel(12'd128, 12'd128);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd255, 12'd255);
        send_pixel(12'd128, 12'd0);
    endtask

    task automatic test_register_writes();
        drain_pixels();
        write_register(CFG_IDX_COLOR, 24'hFFFFFF);
        send_pixel(12'd40, 12'd200);
        drain_pixels();
        // unused index must leave every register alone
        write_register(CFG_IDX_UNUSED, 24'h123456);
        send_pixel(12'd200, 12'd40);
        drain_pixels();
        // upper data bits beyond the size field are dropped
        write_register(CFG_IDX_WIDTH, 24'hFFE010);
        write_register(CFG_IDX_HEIGHT, 24'hABE020);
        send_pixel(12'd3, 12'd30);
        image_settings++;
    endtask

    task automatic test_zero_radius();
        set_image(1, 4096, 24'h0000FF);
        send_pixel(12'd0, 12'd2048);
        set_image(0, 300, 24'h00FF00);
        send_pixel(12'd0, 12'd150);
        set_image(4096, 0, 24'hFF0000);
        send_pixel(12'd2048, 12'd0);
    endtask

    task automatic test_size_extremes();
        set_image(4096, 4096, 24'hA5A5A5);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd2048, 12'd0);
        send_pixel(12'd4095, 12'd0);
        set_image(8191, 8191, 24'h5A5A5A);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
    endtask

    task automatic test_off_image();
        set_image(16, 16, 24'h000000);
        send_pixel(12'd4095, 12'd8);
        send_pixel(12'd0, 12'd4095);
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 5)) inside
            [0:1]: return $urandom_range(1, 32);
            2:     return $urandom_range(33, 512);
            3:     return $urandom_range(513, 4096);
            4:     return $urandom_range(2, 8);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 1;
                    1: return 4096;
                    2: return 8191;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord(input int size);
        if (size == 0 || $urandom_range(0, 4) == 0)
            return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
        return COORD_BITS'($urandom_range(0, ((size > 4096) ? 4096 : size) - 1));
    endfunction

    task automatic test_random_images();
        int sent, phase_len, w, h;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            w = pick_size();
            h = ($urandom_range(0, 2) == 0) ? w : pick_size();
            set_image(w, h, COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1)));
            if ($urandom_range(0, 4) == 0)
                write_register(CFG_IDX_UNUSED,
                               CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
            phase_len = $urandom_range(40, 110);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                send_pixel(pick_coord(w), pick_coord(h));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_register_writes();
        test_zero_radius();
        test_size_extremes();
        test_off_image();
        test_random_images();
        drain_pixels();
        repeat (LATENCY + 4) @(posedge clk);
        $display("checked %0d of %0d pixels over %0d image settings", pixels_checked,
                 pixels_sent, image_settings);
        $display("%0d register transfers, %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- radial_alpha_gradient.f -----
+incdir+design
design/rag_pkg.sv
design/rag_prep.sv
design/rag_search.sv
design/radial_alpha_gradient.sv
tb/tb.sv
